FILE: src/elevator_hall_call_dispatcher_assert.svh
// ----------------------------------------------------------------------------
// Hall call dispatcher assertion macros
// Clocked assertion wrappers shared by the dispatcher RTL.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_HALL_CALL_DISPATCHER_ASSERT_SVH
`define ELEVATOR_HALL_CALL_DISPATCHER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HCD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hall call dispatcher check failed");

// Next-cycle implication.
`define HCD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hall call dispatcher check failed");

`endif

FILE: src/hcd_pkg.sv
// ----------------------------------------------------------------------------
// Hall call dispatcher package
// Sizes, codes, car entry layout and shared helpers.
// ----------------------------------------------------------------------------
package hcd_pkg;

    localparam int NUM_CARS   = 4;
    localparam int NUM_FLOORS = 20;

    localparam int CMD_W   = 2;
    localparam int CAR_W   = 2;
    localparam int FLOOR_W = 5;
    localparam int DIR_W   = 2;
    localparam int TIME_W  = 8;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam int STOP_COST  = 7;
    localparam int COST_LIMIT = 2000;
    localparam int TIME_MAX   = 255;
    localparam int COST_W     = $clog2(COST_LIMIT + 1);

    localparam int CAR_IDX_W  = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
    // floor walker runs from 0 to NUM_FLOORS+1 (one past either end)
    localparam int WALK_W     = $clog2(NUM_FLOORS + 2);
    localparam int STOP_IDX_W = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;

    // commands (tuser on the input side)
    localparam logic [CMD_W-1:0] CMD_STATUS = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STOP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CALL   = 2'd2;

    // stored direction codes, two's complement
    localparam logic [DIR_W-1:0] DIR_IDLE = 2'b00;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'b11;

    localparam logic STATUS_ASSIGNED = 1'b0;
    localparam logic STATUS_DROPPED  = 1'b1;

    typedef struct packed {
        logic [NUM_FLOORS-1:0] stops;
        logic [DIR_W-1:0]      dir;
        logic [FLOOR_W-1:0]    floor;
    } car_entry_t;

    localparam int ENTRY_W = NUM_FLOORS + DIR_W + FLOOR_W;

    localparam car_entry_t ENTRY_RESET = '{
        stops: '0,
        dir:   DIR_IDLE,
        floor: FLOOR_W'(1)
    };

    typedef struct packed {
        logic                  start;
        logic [FLOOR_W-1:0]    floor;
        logic [DIR_W-1:0]      dir;
        logic [NUM_FLOORS-1:0] stops;
        logic [FLOOR_W-1:0]    target;
    } cost_req_t;

    typedef struct packed {
        logic              done;
        logic [COST_W-1:0] cost;
    } cost_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_UPDATE,
        ST_CALL_RD,
        ST_CALL_LOAD,
        ST_CALL_COST,
        ST_SET_RD,
        ST_SET_WR,
        ST_OUT
    } disp_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SCAN,
        CS_WALK,
        CS_DONE
    } cost_state_t;

    function automatic logic floor_in_range(input logic [WALK_W-1:0] pos);
        return (pos != '0) && (pos <= WALK_W'(NUM_FLOORS));
    endfunction

    // stop bit of floor pos (floors count from 1); off the shaft reads as no stop
    function automatic logic floor_is_stop(input logic [NUM_FLOORS-1:0] stops,
                                           input logic [WALK_W-1:0]     pos);
        logic [WALK_W-1:0] idx;
        idx = pos - WALK_W'(1);
        if (!floor_in_range(pos))
            return 1'b0;
        return stops[idx[STOP_IDX_W-1:0]];
    endfunction

endpackage

FILE: src/hcd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/hcd_cost.sv
// ----------------------------------------------------------------------------
// Hall call cost walker
// Walks one car's floors, one floor per cycle, and returns its cost.
// ----------------------------------------------------------------------------
module hcd_cost (
    input  logic              clk,
    input  logic              rst_n,
    input  hcd_pkg::cost_req_t req,
    output hcd_pkg::cost_rsp_t rsp
);

    hcd_pkg::cost_state_t state_reg, state_next;

    logic [hcd_pkg::WALK_W-1:0]     pos_reg, pos_next;
    logic [hcd_pkg::WALK_W-1:0]     far_reg, far_next;
    logic [hcd_pkg::WALK_W-1:0]     start_reg, start_next;
    logic [hcd_pkg::WALK_W-1:0]     target_reg, target_next;
    logic [hcd_pkg::DIR_W-1:0]      step_reg, step_next;
    logic [hcd_pkg::DIR_W-1:0]      scan_reg, scan_next;
    logic [hcd_pkg::NUM_FLOORS-1:0] stops_reg, stops_next;
    logic [hcd_pkg::COST_W-1:0]     acc_reg, acc_next;

    logic [hcd_pkg::WALK_W-1:0] req_c;
    logic [hcd_pkg::WALK_W-1:0] req_t;
    logic [hcd_pkg::DIR_W-1:0]  req_td;
    logic                       req_away;
    logic                       cur_stop;
    logic [hcd_pkg::WALK_W-1:0] back_dist;

    assign req_c    = hcd_pkg::WALK_W'(req.floor);
    assign req_t    = hcd_pkg::WALK_W'(req.target);
    assign req_td   = (req_t > req_c) ? hcd_pkg::DIR_UP : hcd_pkg::DIR_DOWN;
    assign req_away = (req.dir != hcd_pkg::DIR_IDLE) && (req.dir != req_td);
    assign cur_stop = hcd_pkg::floor_is_stop(stops_reg, pos_reg);
    assign back_dist = (far_reg > start_reg) ? (far_reg - start_reg)
                                             : (start_reg - far_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hcd_pkg::CS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        far_reg    <= far_next;
        start_reg  <= start_next;
        target_reg <= target_next;
        step_reg   <= step_next;
        scan_reg   <= scan_next;
        stops_reg  <= stops_next;
        acc_reg    <= acc_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        far_next    = far_reg;
        start_next  = start_reg;
        target_next = target_reg;
        step_next   = step_reg;
        scan_next   = scan_reg;
        stops_next  = stops_reg;
        acc_next    = acc_reg;
        rsp.done    = 1'b0;
        rsp.cost    = acc_reg;

        case (state_reg)
            hcd_pkg::CS_IDLE:
            begin
                if (req.start)
                begin
                    pos_next    = req_c;
                    far_next    = req_c;
                    start_next  = req_c;
                    target_next = req_t;
                    step_next   = req_td;
                    scan_next   = req.dir;
                    stops_next  = req.stops;
                    acc_next    = '0;
                    if (req_t == req_c)
                        state_next = hcd_pkg::CS_DONE;
                    else if (req_away)
                        state_next = hcd_pkg::CS_SCAN;
                    else
                        state_next = hcd_pkg::CS_WALK;
                end
            end

            // run out to the end floor, remembering the farthest stop
            hcd_pkg::CS_SCAN:
            begin
                if (hcd_pkg::floor_in_range(pos_reg))
                begin
                    if (cur_stop)
                        far_next = pos_reg;
                    pos_next = pos_reg + {{(hcd_pkg::WALK_W-2){scan_reg[1]}}, scan_reg};
                end
                else
                begin
                    pos_next   = far_reg;
                    acc_next   = hcd_pkg::COST_W'(back_dist);
                    state_next = hcd_pkg::CS_WALK;
                end
            end

            // walk toward the call floor, call floor itself not counted
            hcd_pkg::CS_WALK:
            begin
                if (pos_reg != target_reg && hcd_pkg::floor_in_range(pos_reg))
                begin
                    acc_next = acc_reg + (cur_stop ? hcd_pkg::COST_W'(hcd_pkg::STOP_COST + 1)
                                                   : hcd_pkg::COST_W'(1));
                    pos_next = pos_reg + {{(hcd_pkg::WALK_W-2){step_reg[1]}}, step_reg};
                end
                else
                begin
                    state_next = hcd_pkg::CS_DONE;
                end
            end

            hcd_pkg::CS_DONE:
            begin
                rsp.done   = 1'b1;
                state_next = hcd_pkg::CS_IDLE;
            end

            default:
            begin
                state_next = hcd_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

FILE: src/elevator_hall_call_dispatcher.sv
// Status and stop writes pass through accept, RAM read and write back. Hall calls take,
// per car, a RAM read, a load and a done step plus the cost walker's scan and walk steps;
// a dropped call goes straight to the output. Throughput: one item at a time; a finished
// result waits in the output register while the next item is taken. Reset: asynchronous,
// active low; every car reads as floor 1, idle, no stops through per-entry valid flags,
// no clearing pass.
// ----------------------------------------------------------------------------
// Elevator hall call dispatcher
// Car state lives in a small RAM; a sequencer reads, updates and writes it back,
// and for hall calls runs each car through the cost walker and picks the cheapest.
// ----------------------------------------------------------------------------
`include "elevator_hall_call_dispatcher_assert.svh"

module elevator_hall_call_dispatcher (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // car[1:0], floor[6:2], direction[8:7], stop_value[9], call_pending[10], zero fill
    input  logic [hcd_pkg::IN_TDATA_W-1:0]     s_tdata,
    // cmd[1:0]
    input  logic [hcd_pkg::CMD_W-1:0]          s_tuser,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // assigned_car[1:0], estimated_time[9:2], zero fill
    output logic [hcd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // status[0]
    output logic                               m_tuser
);

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic [hcd_pkg::CAR_W-1:0]   in_car;
    logic [hcd_pkg::FLOOR_W-1:0] in_floor;
    logic [hcd_pkg::DIR_W-1:0]   in_dir;
    logic                        in_stop_value;
    logic                        in_pending;

    assign in_car        = s_tdata[1:0];
    assign in_floor      = s_tdata[6:2];
    assign in_dir        = s_tdata[8:7];
    assign in_stop_value = s_tdata[9];
    assign in_pending    = s_tdata[10];

    logic                        in_car_ok;
    logic                        in_floor_ok;
    logic [hcd_pkg::FLOOR_W-1:0] in_floor_sat;
    logic [hcd_pkg::DIR_W-1:0]   in_dir_norm;

    assign in_car_ok   = 32'(in_car) < 32'(hcd_pkg::NUM_CARS);
    assign in_floor_ok = (in_floor != '0) && (32'(in_floor) <= 32'(hcd_pkg::NUM_FLOORS));

    // status floor saturates into the shaft
    always_comb
    begin
        if (in_floor == '0)
            in_floor_sat = hcd_pkg::FLOOR_W'(1);
        else if (32'(in_floor) > 32'(hcd_pkg::NUM_FLOORS))
            in_floor_sat = hcd_pkg::FLOOR_W'(hcd_pkg::NUM_FLOORS);
        else
            in_floor_sat = in_floor;
    end

    // -2 is taken as down
    assign in_dir_norm = (in_dir == hcd_pkg::DIR_UP) ? hcd_pkg::DIR_UP :
                         (in_dir[1] ? hcd_pkg::DIR_DOWN : hcd_pkg::DIR_IDLE);

    // ------------------------------------------------------------------
    // State and registers
    // ------------------------------------------------------------------
    hcd_pkg::disp_state_t state_reg, state_next;

    logic [hcd_pkg::NUM_CARS-1:0]  valid_reg, valid_next;
    logic                          m_tvalid_reg, m_tvalid_next;

    logic [hcd_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [hcd_pkg::CAR_IDX_W-1:0] car_reg, car_next;
    logic [hcd_pkg::FLOOR_W-1:0]   floor_reg, floor_next;
    logic [hcd_pkg::DIR_W-1:0]     dir_reg, dir_next;
    logic                          sv_reg, sv_next;
    logic [hcd_pkg::CAR_IDX_W-1:0] k_reg, k_next;
    logic [hcd_pkg::CAR_IDX_W-1:0] win_reg, win_next;
    logic [hcd_pkg::COST_W-1:0]    best_reg, best_next;
    logic                          drop_reg, drop_next;
    logic [hcd_pkg::CAR_IDX_W-1:0] rd_addr_reg, rd_addr_next;

    logic [hcd_pkg::CAR_W-1:0]     out_car_reg, out_car_next;
    logic [hcd_pkg::TIME_W-1:0]    out_time_reg, out_time_next;
    logic                          out_status_reg, out_status_next;

    // ------------------------------------------------------------------
    // Car state RAM
    // ------------------------------------------------------------------
    logic                          mem_we;
    logic [hcd_pkg::CAR_IDX_W-1:0] mem_waddr;
    hcd_pkg::car_entry_t           mem_wdata;
    logic                          mem_re;
    logic [hcd_pkg::CAR_IDX_W-1:0] mem_raddr;
    logic [hcd_pkg::ENTRY_W-1:0]   mem_rdata;
    hcd_pkg::car_entry_t           entry;

    hcd_ram #(
        .WIDTH (hcd_pkg::ENTRY_W),
        .DEPTH (hcd_pkg::NUM_CARS)
    ) u_car_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // a never-written car reads as its reset state
    assign entry = valid_reg[rd_addr_reg] ? hcd_pkg::car_entry_t'(mem_rdata)
                                          : hcd_pkg::ENTRY_RESET;

    // ------------------------------------------------------------------
    // Cost walker
    // ------------------------------------------------------------------
    hcd_pkg::cost_req_t cost_req;
    hcd_pkg::cost_rsp_t cost_rsp;

    assign cost_req.floor  = entry.floor;
    assign cost_req.dir    = entry.dir;
    assign cost_req.stops  = entry.stops;
    assign cost_req.target = floor_reg;
    assign cost_req.start  = (state_reg == hcd_pkg::ST_CALL_LOAD);

    hcd_cost u_cost (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cost_req),
        .rsp   (cost_rsp)
    );

    // stop bit of the latched floor
    logic [hcd_pkg::NUM_FLOORS-1:0] floor_mask;
    assign floor_mask = hcd_pkg::NUM_FLOORS'(1) << (floor_reg - hcd_pkg::FLOOR_W'(1));

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= hcd_pkg::ST_IDLE;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        car_reg        <= car_next;
        floor_reg      <= floor_next;
        dir_reg        <= dir_next;
        sv_reg         <= sv_next;
        k_reg          <= k_next;
        win_reg        <= win_next;
        best_reg       <= best_next;
        drop_reg       <= drop_next;
        rd_addr_reg    <= rd_addr_next;
        out_car_reg    <= out_car_next;
        out_time_reg   <= out_time_next;
        out_status_reg <= out_status_next;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        cmd_next        = cmd_reg;
        car_next        = car_reg;
        floor_next      = floor_reg;
        dir_next        = dir_reg;
        sv_next         = sv_reg;
        k_next          = k_reg;
        win_next        = win_reg;
        best_next       = best_reg;
        drop_next       = drop_reg;
        rd_addr_next    = rd_addr_reg;
        out_car_next    = out_car_reg;
        out_time_next   = out_time_reg;
        out_status_next = out_status_reg;

        // output register drains independently
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = car_reg;
        mem_wdata = entry;
        mem_re    = 1'b0;
        mem_raddr = car_reg;

        case (state_reg)
            hcd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd_next = s_tuser;
                    car_next = hcd_pkg::CAR_IDX_W'(in_car);
                    sv_next  = in_stop_value;
                    dir_next = in_dir_norm;
                    case (s_tuser)
                        hcd_pkg::CMD_STATUS:
                        begin
                            floor_next = in_floor_sat;
                            if (in_car_ok)
                                state_next = hcd_pkg::ST_RD;
                        end
                        hcd_pkg::CMD_STOP:
                        begin
                            floor_next = in_floor;
                            if (in_car_ok && in_floor_ok)
                                state_next = hcd_pkg::ST_RD;
                        end
                        hcd_pkg::CMD_CALL:
                        begin
                            floor_next = in_floor;
                            k_next     = '0;
                            win_next   = '0;
                            if (!in_pending || !in_floor_ok)
                            begin
                                // stale or off-shaft call: answered as dropped
                                best_next  = '0;
                                drop_next  = hcd_pkg::STATUS_DROPPED;
                                state_next = hcd_pkg::ST_OUT;
                            end
                            else
                            begin
                                best_next  = hcd_pkg::COST_W'(hcd_pkg::COST_LIMIT);
                                drop_next  = hcd_pkg::STATUS_ASSIGNED;
                                state_next = hcd_pkg::ST_CALL_RD;
                            end
                        end
                        default:
                        begin
                            // unused command: no effect, no result
                            state_next = hcd_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // status or stop write: read the entry
            hcd_pkg::ST_RD:
            begin
                mem_re       = 1'b1;
                mem_raddr    = car_reg;
                rd_addr_next = car_reg;
                state_next   = hcd_pkg::ST_UPDATE;
            end

            // modify and write back
            hcd_pkg::ST_UPDATE:
            begin
                mem_we    = 1'b1;
                mem_waddr = car_reg;
                mem_wdata = entry;
                if (cmd_reg == hcd_pkg::CMD_STATUS)
                begin
                    mem_wdata.floor = floor_reg;
                    mem_wdata.dir   = dir_reg;
                end
                else if (sv_reg)
                begin
                    mem_wdata.stops = entry.stops | floor_mask;
                end
                else
                begin
                    mem_wdata.stops = entry.stops & ~floor_mask;
                end
                valid_next[car_reg] = 1'b1;
                state_next          = hcd_pkg::ST_IDLE;
            end

            hcd_pkg::ST_CALL_RD:
            begin
                mem_re       = 1'b1;
                mem_raddr    = k_reg;
                rd_addr_next = k_reg;
                state_next   = hcd_pkg::ST_CALL_LOAD;
            end

            // entry is on the RAM output; cost walker starts here
            hcd_pkg::ST_CALL_LOAD:
            begin
                state_next = hcd_pkg::ST_CALL_COST;
            end

            hcd_pkg::ST_CALL_COST:
            begin
                if (cost_rsp.done)
                begin
                    // strict compare keeps the lowest car number on ties
                    if (cost_rsp.cost < best_reg)
                    begin
                        best_next = cost_rsp.cost;
                        win_next  = k_reg;
                    end
                    if (k_reg == hcd_pkg::CAR_IDX_W'(hcd_pkg::NUM_CARS - 1))
                    begin
                        state_next = hcd_pkg::ST_SET_RD;
                    end
                    else
                    begin
                        k_next     = k_reg + hcd_pkg::CAR_IDX_W'(1);
                        state_next = hcd_pkg::ST_CALL_RD;
                    end
                end
            end

            // winner gets the call floor as a stop
            hcd_pkg::ST_SET_RD:
            begin
                mem_re       = 1'b1;
                mem_raddr    = win_reg;
                rd_addr_next = win_reg;
                state_next   = hcd_pkg::ST_SET_WR;
            end

            hcd_pkg::ST_SET_WR:
            begin
                mem_we              = 1'b1;
                mem_waddr           = win_reg;
                mem_wdata           = entry;
                mem_wdata.stops     = entry.stops | floor_mask;
                valid_next[win_reg] = 1'b1;
                state_next          = hcd_pkg::ST_OUT;
            end

            // hand the result to the output register once it is free
            hcd_pkg::ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_car_next    = hcd_pkg::CAR_W'(win_reg);
                    out_time_next   = (best_reg > hcd_pkg::COST_W'(hcd_pkg::TIME_MAX))
                                      ? hcd_pkg::TIME_W'(hcd_pkg::TIME_MAX)
                                      : best_reg[hcd_pkg::TIME_W-1:0];
                    out_status_next = drop_reg;
                    state_next      = hcd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = hcd_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(hcd_pkg::OUT_TDATA_W - hcd_pkg::CAR_W - hcd_pkg::TIME_W){1'b0}},
                       out_time_reg, out_car_reg};
    assign m_tuser  = out_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a new result only comes out of the result hand-off state
    `HCD_ASSERT_IMP(a_result_from_out, $rose(m_tvalid), $past(state_reg) == hcd_pkg::ST_OUT)
    // cost walker only answers while the sequencer waits for it
    `HCD_ASSERT_IMP(a_cost_done_wait, cost_rsp.done, state_reg == hcd_pkg::ST_CALL_COST)
    // a dropped call carries no car and no cost
    `HCD_ASSERT_IMP(a_drop_clean, m_tvalid && (m_tuser == hcd_pkg::STATUS_DROPPED),
                    (out_car_reg == '0) && (out_time_reg == '0))
    // every RAM write returns the sequencer to a hand-off point
    `HCD_ASSERT_NXT(a_write_then_idle, mem_we,
                    (state_reg == hcd_pkg::ST_IDLE) || (state_reg == hcd_pkg::ST_OUT))

endmodule

FILE: bench/elevator_hall_call_dispatcher_test.sv
// ----------------------------------------------------------------------------
// Hall call dispatcher testbench
// Drives status, stop, hall-call and unused-command transfers into the
// dispatcher under random sender bursts and receiver stalls. It predicts each
// call result from its own copy of the car table and checks every result, in
// order, field by field.
// ----------------------------------------------------------------------------
module elevator_hall_call_dispatcher_test;

    import hcd_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_LEN   = 12;
    localparam int PHASES      = 4;
    localparam int PHASE_ITEMS = 170;     // counted items per random phase
    localparam int TAIL_WAIT   = 200;     // settle time after the last drain, sized for a worst-case hall call
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SHOW_MAX    = 10;

    // command code the block does not define; it must be swallowed silently
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
    // -2 in the direction field, taken as down
    localparam logic [DIR_W-1:0] DIR_DOWN_ALT = 2'b10;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [CAR_W-1:0]   car;
        logic [FLOOR_W-1:0] floor;
        logic [DIR_W-1:0]   dir;
        logic               stop_value;
        logic               pending;
    } hall_item_t;

    typedef struct packed {
        logic [CAR_W-1:0]  car;
        logic [TIME_W-1:0] eta;
        logic              status;
    } dispatch_t;

    // ------------------------------------------------------------------------
    // Car table predictor and queue of awaited dispatch results
    // ------------------------------------------------------------------------
    class hall_call_scoreboard;
        int                    car_floor [NUM_CARS];
        int                    car_dir   [NUM_CARS];
        logic [NUM_FLOORS-1:0] car_stops [NUM_CARS];
        dispatch_t             awaited_q [$];
        int failures;
        int n_status, n_stop, n_ignored, n_assigned, n_dropped, n_checked;

        function new();
            for (int k = 0; k < NUM_CARS; k++)
            begin
                car_floor[k] = 1;
                car_dir[k]   = 0;
                car_stops[k] = '0;
            end
        endfunction

        function bit stop_at(int k, int f);
            if (f < 1 || f > NUM_FLOORS)
                return 1'b0;
            return car_stops[k][f-1];
        endfunction

        // each floor passed costs 1, a stop on it 7 more; the target is excluded
        function int unsigned walk_cost(int k, int from, int to, int step);
            int unsigned sum;
            int          i;
            sum = 0;
            i   = from;
            while (i != to && i >= 1 && i <= NUM_FLOORS)
            begin
                sum += 1 + (stop_at(k, i) ? STOP_COST : 0);
                i   += step;
            end
            return sum;
        endfunction

        function int unsigned car_cost(int k, int t);
            int c, d, td, far, i;
            c  = car_floor[k];
            d  = car_dir[k];
            td = (t > c) ? 1 : ((t < c) ? -1 : 0);
            if (td == 0)
                return 0;
            if (td * d < 0)
            begin
                // heading away: run out to the farthest stop, end floor included
                far = c;
                i   = c;
                while (i >= 1 && i <= NUM_FLOORS)
                begin
                    if (stop_at(k, i))
                        far = i;
                    i += d;
                end
                return ((far > c) ? far - c : c - far) + walk_cost(k, far, t, td);
            end
            return walk_cost(k, c, t, td);
        endfunction

        function void note_input(hall_item_t it);
            int          f;
            int unsigned best, cst;
            int          win;
            dispatch_t   res;
            f = int'(it.floor);
            case (it.cmd)
                CMD_STATUS:
                begin
                    n_status++;
                    if (int'(it.car) < NUM_CARS)
                    begin
                        if (f < 1) f = 1;
                        if (f > NUM_FLOORS) f = NUM_FLOORS;
                        car_floor[it.car] = f;
                        car_dir[it.car]   = (it.dir == DIR_UP) ? 1 :
                                            ((it.dir == DIR_IDLE) ? 0 : -1);
                    end
                end
                CMD_STOP:
                begin
                    n_stop++;
                    if (int'(it.car) < NUM_CARS && f >= 1 && f <= NUM_FLOORS)
                        car_stops[it.car][f-1] = it.stop_value;
                end
                CMD_CALL:
                begin
                    if (!it.pending || f < 1 || f > NUM_FLOORS)
                    begin
                        res = '{car: '0, eta: '0, status: STATUS_DROPPED};
                        n_dropped++;
                    end
                    else
                    begin
                        best = COST_LIMIT;
                        win  = 0;
                        for (int k = 0; k < NUM_CARS; k++)
                        begin
                            cst = car_cost(k, f);
                            if (cst < best)
                            begin
                                best = cst;
                                win  = k;
                            end
                        end
                        car_stops[win][f-1] = 1'b1;
                        res.car    = CAR_W'(win);
                        res.eta    = (best > TIME_MAX) ? TIME_W'(TIME_MAX) : TIME_W'(best);
                        res.status = STATUS_ASSIGNED;
                        n_assigned++;
                    end
                    awaited_q.push_back(res);
                end
                default:
                    n_ignored++;
            endcase
        endfunction

        function void fail(string what);
            failures++;
            if (failures <= SHOW_MAX)
                $display("[%0t] FAIL: %s", $time, what);
        endfunction

        function void check_result(dispatch_t got);
            dispatch_t exp;
            if (awaited_q.size() == 0)
            begin
                fail($sformatf("result car=%0d eta=%0d status=%0d with no call waiting",
                               got.car, got.eta, got.status));
                return;
            end
            exp = awaited_q.pop_front();
            n_checked++;
            if (got.car !== exp.car || got.eta !== exp.eta || got.status !== exp.status)
                fail($sformatf("expected car=%0d eta=%0d status=%0d, got car=%0d eta=%0d status=%0d",
                               exp.car, exp.eta, exp.status, got.car, got.eta, got.status));
        endfunction

        function void close_out();
            while (awaited_q.size() != 0)
            begin
                void'(awaited_q.pop_front());
                fail("dispatch result never arrived");
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [CMD_W-1:0]       s_tuser  = CMD_STATUS;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    hall_call_scoreboard sb;

    int rx_mode   = 0;        // 0 always ready, 1 coin flip, 2 long stall runs
    int rx_left   = 0;
    bit rx_open   = 1'b1;

    elevator_hall_call_dispatcher u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF clk = ~clk;

    // Receiver: stall pattern chosen per phase, driven on the falling edge.
    always @(negedge clk)
    begin
        case (rx_mode)
            0: m_tready = 1'b1;
            1: m_tready = 1'($urandom_range(0, 1));
            default:
            begin
                if (rx_left == 0)
                begin
                    rx_open = !rx_open;
                    rx_left = rx_open ? $urandom_range(1, 4) : $urandom_range(1, 20);
                end
                rx_left--;
                m_tready = rx_open;
            end
        endcase
    end

    // Monitor: results are checked before the same edge's input is noted, so a
    // result can never be matched against a call taken on that very edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result('{car: m_tdata[1:0], eta: m_tdata[9:2], status: m_tuser});
            if (s_tvalid && s_tready)
                sb.note_input('{cmd:        s_tuser,
                                car:        s_tdata[1:0],
                                floor:      s_tdata[6:2],
                                dir:        s_tdata[8:7],
                                stop_value: s_tdata[9],
                                pending:    s_tdata[10]});
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("elevator_hall_call_dispatcher: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender side; every task starts and ends just after a falling edge
    // ------------------------------------------------------------------------
    task automatic send(input hall_item_t it);
        s_tuser  = it.cmd;
        s_tdata  = {5'b0, it.pending, it.stop_value, it.dir, it.floor, it.car};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic put(input logic [CMD_W-1:0] cmd, input int car, input int fl,
                       input logic [DIR_W-1:0] dir, input bit sv, input bit pend);
        send('{cmd: cmd, car: CAR_W'(car), floor: FLOOR_W'(fl), dir: dir,
               stop_value: sv, pending: pend});
    endtask

    task automatic gap(input int n);
        if (n > 0)
        begin
            s_tvalid = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // hold off until every awaited result has been taken
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.awaited_q.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic hall_item_t rand_item();
        hall_item_t it;
        int         r;
        r = $urandom_range(0, 99);
        it.cmd = (r < 30) ? CMD_STATUS : (r < 62) ? CMD_STOP : (r < 96) ? CMD_CALL : CMD_UNUSED;
        it.car = CAR_W'($urandom_range(0, 3));
        // mostly floors on the shaft, now and then anything the field holds
        if ($urandom_range(0, 19) == 0)
            it.floor = FLOOR_W'($urandom_range(0, 31));
        else
            it.floor = FLOOR_W'($urandom_range(1, NUM_FLOORS));
        case ($urandom_range(0, 9))
            0:       it.dir = DIR_DOWN_ALT;
            1, 2, 3: it.dir = DIR_IDLE;
            4, 5, 6: it.dir = DIR_UP;
            default: it.dir = DIR_DOWN;
        endcase
        it.stop_value = ($urandom_range(0, 9) < 4);
        it.pending    = ($urandom_range(0, 9) != 0);
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        hall_item_t it;
        int         counted;
        int         max_gap;

        sb = new();
        repeat (RESET_LEN) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: field extremes, every command, the corner cases.
        rx_mode = 0;
        put(CMD_STATUS, 0, 0,  DIR_IDLE,     0, 0);  // floor below range saturates to 1
        put(CMD_STATUS, 1, 31, DIR_DOWN_ALT, 1, 1);  // floor saturates to top, -2 is down
        put(CMD_STATUS, 2, 20, DIR_UP,       0, 0);
        put(CMD_STATUS, 3, 10, DIR_DOWN,     0, 0);
        put(CMD_STOP,   0, 0,  DIR_IDLE,     1, 0);  // stop floor 0: ignored
        put(CMD_STOP,   1, 21, DIR_IDLE,     1, 0);  // stop above shaft: ignored
        put(CMD_STOP,   3, 1,  DIR_IDLE,     1, 0);  // bottom end floor stop for the scan
        put(CMD_STOP,   1, 20, DIR_IDLE,     1, 0);  // top end floor stop
        put(CMD_STOP,   0, 5,  DIR_IDLE,     1, 0);
        put(CMD_STOP,   0, 5,  DIR_IDLE,     0, 0);  // and clear it again
        put(CMD_UNUSED, 3, 31, 2'b11,        1, 1);  // unused command, all ones
        put(CMD_CALL,   0, 7,  DIR_IDLE,     0, 0);  // stale call
        put(CMD_CALL,   0, 0,  DIR_IDLE,     0, 1);  // call floor 0: dropped
        put(CMD_CALL,   3, 31, 2'b11,        1, 1);  // call floor 31: dropped
        put(CMD_CALL,   0, 1,  DIR_IDLE,     0, 1);  // car 0 already there
        put(CMD_CALL,   0, 20, DIR_IDLE,     0, 1);  // tie between cars 1 and 2
        put(CMD_CALL,   0, 15, DIR_IDLE,     0, 1);  // car 3 heads away first
        put(CMD_STATUS, 2, 12, DIR_UP,       0, 0);
        put(CMD_CALL,   0, 11, DIR_IDLE,     0, 1);
        put(CMD_STATUS, 0, 20, DIR_UP,       0, 0);
        put(CMD_CALL,   0, 2,  DIR_IDLE,     0, 1);
        put(CMD_CALL,   0, 12, DIR_IDLE,     0, 1);
        drain();

        // Random phases, each under its own sender and receiver pressure,
        // separated by a full drain of awaited results.
        for (int p = 0; p < PHASES; p++)
        begin
            rx_mode = p % 3;
            max_gap = (p == PHASES - 1) ? 0 : 6 * (p + 1);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                repeat ($urandom_range(1, 12))
                begin
                    it = rand_item();
                    send(it);
                    if (it.cmd != CMD_UNUSED)
                        counted++;
                end
                if (max_gap > 0 && $urandom_range(0, 3) != 0)
                    gap($urandom_range(1, max_gap));
            end
            drain();
        end

        // nothing awaited any more: allow a stray late result to show up
        rx_mode = 0;
        repeat (TAIL_WAIT) @(posedge clk);
        sb.close_out();

        $display("run covered %0d status writes, %0d stop writes, %0d unused commands",
                 sb.n_status, sb.n_stop, sb.n_ignored);
        $display("and %0d hall calls assigned, %0d dropped, %0d results checked",
                 sb.n_assigned, sb.n_dropped, sb.n_checked);
        if (sb.failures == 0)
            $display("elevator_hall_call_dispatcher: match");
        else
            $display("elevator_hall_call_dispatcher: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/hcd_pkg.sv
src/hcd_ram.sv
src/hcd_cost.sv
src/elevator_hall_call_dispatcher.sv
bench/elevator_hall_call_dispatcher_test.sv
